### hdl/fbfl_pkg.sv
// Package for the fixed-block free-list allocator.
// Holds pool sizing constants, request and flag codes, and the
// controller-to-datapath command and status types. No dependencies.
package fbfl_pkg;

    // Pool sizing: the block index, the link (index plus a null code) and one RAM entry.
    localparam int BLK_MAX = 256;
    localparam int IDX_W   = $clog2(BLK_MAX);
    localparam int LINK_W  = IDX_W + 1;
    localparam int FLAG_W  = 2;
    localparam int ENT_W   = FLAG_W + LINK_W;

    // The null link and the largest pool share one value.
    localparam logic [LINK_W-1:0] POOL_MAX  = LINK_W'(BLK_MAX);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(BLK_MAX);

    // Block flag codes as stored in the RAM.
    localparam logic [FLAG_W-1:0] FLAG_INVALID  = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_INACTIVE = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_ACTIVE   = 2'd2;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_INIT  = 2'd3
    } req_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the request and issue the first RAM read
        logic exec;   // carry out one update step of the captured request
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;   // the current update step completes the request
    } dp_status_t;

endpackage

### hdl/fbfl_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No package dependencies.
module fbfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; a read of the address being written returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/fbfl_ctrl.sv
// Controller state machine for the fixed-block free-list allocator.
// Depends on fbfl_pkg for the command and status types.
module fbfl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output fbfl_pkg::dp_cmd_t    cmd,
    input  fbfl_pkg::dp_status_t status
);

    import fbfl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   done_reg;

    // A request is taken only in idle; every run cycle is one update step.
    always_comb
    begin
        cmd.load = (state_reg == ST_IDLE) && start;
        cmd.exec = (state_reg == ST_RUN);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // State and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (status.last)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/fbfl_dpath.sv
// Datapath of the fixed-block free-list allocator: link/flag RAM with
// per-entry written bits, head, used count, walk counter and result registers.
// Depends on fbfl_pkg and fbfl_ram.
module fbfl_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fbfl_pkg::dp_cmd_t                  cmd,
    output fbfl_pkg::dp_status_t               status,
    input  logic                               cfg_wr_en,
    input  logic [fbfl_pkg::LINK_W-1:0]        num_blocks,
    input  logic [1:0]                         req_type,
    input  logic [fbfl_pkg::IDX_W-1:0]         free_index,
    output logic [fbfl_pkg::IDX_W-1:0]         block_index,
    output logic                               ok,
    output logic [fbfl_pkg::LINK_W-1:0]        used_blocks
);

    import fbfl_pkg::*;

    // Control state.
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] count_reg, count_next;
    logic [LINK_W-1:0] size_reg;
    logic [BLK_MAX-1:0] vld_reg;
    logic              rd_vld_reg;

    // Request and walk payload.
    req_t              req_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LINK_W-1:0] walk_reg, walk_next;
    logic [IDX_W-1:0]  rd_addr_reg;

    // Result payload.
    logic [IDX_W-1:0]  blk_reg, blk_next;
    logic              ok_reg, ok_next;
    logic [LINK_W-1:0] used_reg;

    // RAM ports.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    // Decoded entry and helpers.
    logic [FLAG_W-1:0] ent_flag;
    logic [LINK_W-1:0] ent_link;
    logic [LINK_W-1:0] pool_n;
    logic [LINK_W-1:0] walk_inc;
    logic              walk_stop;
    logic              last;

    fbfl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (BLK_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective pool size: zero counts as one, anything above the maximum is clamped.
    always_comb
    begin
        if (size_reg == '0)
        begin
            pool_n = LINK_W'(1);
        end
        else if (size_reg > POOL_MAX)
        begin
            pool_n = POOL_MAX;
        end
        else
        begin
            pool_n = size_reg;
        end
    end

    // An entry never written reads as its reset value: invalid, linked to the next index.
    always_comb
    begin
        if (rd_vld_reg)
        begin
            ent_flag = ram_rdata[ENT_W-1:LINK_W];
            ent_link = ram_rdata[LINK_W-1:0];
        end
        else
        begin
            ent_flag = FLAG_INVALID;
            ent_link = LINK_W'(rd_addr_reg) + LINK_W'(1);
        end
    end

    assign walk_inc  = walk_reg + LINK_W'(1);
    assign walk_stop = (walk_reg == pool_n)
                    || ((req_reg == REQ_CLEAR) && (ent_flag == FLAG_INVALID));

    // Read address: taken from the request at load, then the next block while walking.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = walk_inc[IDX_W-1:0];
        if (cmd.load)
        begin
            ram_re = 1'b1;
            case (req_t'(req_type))
                REQ_ALLOC: ram_raddr = head_reg[IDX_W-1:0];
                REQ_FREE:  ram_raddr = free_index;
                default:   ram_raddr = '0;
            endcase
        end
        else if (cmd.exec && (req_reg == REQ_CLEAR || req_reg == REQ_INIT))
        begin
            ram_re = 1'b1;
        end
    end

    // One update step of the captured request.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        walk_next  = walk_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = {FLAG_INVALID, LINK_NULL};
        blk_next   = '0;
        ok_next    = 1'b1;
        last       = 1'b0;
        if (cmd.exec)
        begin
            case (req_reg)
                REQ_ALLOC:
                begin
                    last = 1'b1;
                    if (head_reg >= LINK_NULL)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        blk_next  = head_reg[IDX_W-1:0];
                        head_next = ent_link;
                        ram_we    = 1'b1;
                        ram_waddr = head_reg[IDX_W-1:0];
                        ram_wdata = {FLAG_ACTIVE, ent_link};
                        if (count_reg < POOL_MAX)
                        begin
                            count_next = count_reg + LINK_W'(1);
                        end
                    end
                end
                REQ_FREE:
                begin
                    last = 1'b1;
                    if ((LINK_W'(idx_reg) >= pool_n) || (ent_flag != FLAG_ACTIVE))
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        head_next = LINK_W'(idx_reg);
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg;
                        ram_wdata = {FLAG_INACTIVE, head_reg};
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - LINK_W'(1);
                        end
                    end
                end
                default:
                begin
                    // Clear and init: relink one block per cycle until the stop condition.
                    if (walk_stop)
                    begin
                        last       = 1'b1;
                        head_next  = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = walk_reg[IDX_W-1:0];
                        ram_wdata = {FLAG_INVALID,
                                     (walk_inc < pool_n) ? walk_inc : LINK_NULL};
                        walk_next = walk_inc;
                    end
                end
            endcase
        end
    end

    assign status.last = last;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            size_reg   <= POOL_MAX;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                size_reg <= num_blocks;
            end
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re)
            begin
                rd_vld_reg <= vld_reg[ram_raddr];
            end
        end
    end

    // Request, walk and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_t'(req_type);
            idx_reg  <= free_index;
            walk_reg <= '0;
        end
        else
        begin
            walk_reg <= walk_next;
        end
        if (ram_re)
        begin
            rd_addr_reg <= ram_raddr;
        end
        if (last)
        begin
            blk_reg  <= blk_next;
            ok_reg   <= ok_next;
            used_reg <= count_next;
        end
    end

    assign block_index = blk_reg;
    assign ok          = ok_reg;
    assign used_blocks = used_reg;

endmodule

### hdl/fixed_block_free_list_allocator_core.sv
// Top level of the fixed-block free-list allocator.
// Depends on fbfl_pkg, fbfl_ctrl and fbfl_dpath.
//
// Channel   Ports                                   Transfer
// request   start, busy, req_type, free_index       rising edge with start high, busy low
// result    done, block_index, ok, used_blocks      rising edge ending the cycle done is high
// config    cfg_wr_en, num_blocks                   rising edge with cfg_wr_en high
//
// Allocate and free issue one RAM read of the link/flag entry, then one update step
// that writes the entry back. Clear and init read entry 0, then relink up to 256
// blocks, one block per cycle through the single RAM write port. done is high the
// cycle after the last step, and a new request may be taken in that same cycle. The
// result is shown for exactly one cycle and cannot be held off. Reset needs no
// clearing pass: per-entry written bits stand in for it.
module fixed_block_free_list_allocator_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [7:0] free_index,
    output logic       done,
    output logic [7:0] block_index,
    output logic       ok,
    output logic [8:0] used_blocks,
    input  logic       cfg_wr_en,
    input  logic [8:0] num_blocks
);

    import fbfl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencing of requests.
    fbfl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    // Free list storage and update logic.
    fbfl_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .num_blocks  (num_blocks),
        .req_type    (req_type),
        .free_index  (free_index),
        .block_index (block_index),
        .ok          (ok),
        .used_blocks (used_blocks)
    );

endmodule
